### hdl/dpwsd_pkg.sv
// Shared types and constants for the dual priority work-stealing deque.
// No dependencies; every other file of the block imports this package.
package dpwsd_pkg;

    // Fixed widths of the words on the two channels.
    localparam int OP_W     = 2;
    localparam int TASK_W   = 32;
    localparam int BATCH_W  = 7;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 9;

    // Defaults for the top-level parameters.
    localparam int DEF_DEPTH     = 256;
    localparam int DEF_TASK_BITS = 32;
    localparam int DEF_MAX_BATCH = 64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_STEAL = 2'd2,
        OP_BATCH = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

endpackage

### hdl/dpwsd_ifs.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on dpwsd_pkg for the field widths.
interface dpwsd_req_if;
    import dpwsd_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic                priority_req;
    logic [TASK_W-1:0]   task_req;
    logic [BATCH_W-1:0]  max_batch;

    modport source (output valid, output op, output priority_req, output task_req,
                    output max_batch, input ready);
    modport sink   (input valid, input op, input priority_req, input task_req,
                    input max_batch, output ready);
endinterface

interface dpwsd_rsp_if;
    import dpwsd_pkg::*;

    logic                valid;
    logic                ready;
    logic [TASK_W-1:0]   task_out;
    logic [STATUS_W-1:0] status;
    logic                last;
    logic [LEVEL_W-1:0]  high_level;
    logic [LEVEL_W-1:0]  normal_level;

    modport source (output valid, output task_out, output status, output last,
                    output high_level, output normal_level, input ready);
    modport sink   (input valid, input task_out, input status, input last,
                    input high_level, input normal_level, output ready);
endinterface

### hdl/dual_priority_work_steal_deque.sv
// Top level of the dual priority work-stealing deque.
// Depends on dpwsd_pkg and on the channel interfaces in dpwsd_ifs.sv.
//
// Two bounded task deques, high and normal priority, share one memory of
// 2*DEPTH task handles; the high deque owns the upper half. Each deque is a
// ring addressed by a top and a bottom pointer that count modulo 2*DEPTH, so
// a full deque is told apart from an empty one. A request word is taken only
// when the sequencer is idle. A push writes its task and loads its response
// word in the execute state; a pop or steal issues its first read there and
// emits from the read state, a batch steal one word per cycle while taken.
// This order is set by the single memory port with its registered read and
// by the one pointer adder that moves every pointer. A response word that
// is not yet taken stalls the sequencer but not the acceptance of the next
// request. Pop and steal serve the high deque first; a batch steal removes
// half the tasks of the chosen deque, rounded up and capped by the requested
// limit and by MAX_BATCH, and flags its final word with last. Every response
// word carries both fill levels as they stand after that word.
module dual_priority_work_steal_deque #(
    parameter int DEPTH     = dpwsd_pkg::DEF_DEPTH,
    parameter int TASK_BITS = dpwsd_pkg::DEF_TASK_BITS,
    parameter int MAX_BATCH = dpwsd_pkg::DEF_MAX_BATCH
) (
    input  logic        clk,
    input  logic        rst_n,
    dpwsd_req_if.sink   req,
    dpwsd_rsp_if.source rsp
);
    import dpwsd_pkg::*;

    // Pointer and address geometry. The extra pointer bit separates full from
    // empty; the memory address is the deque select above the ring slot.
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int PTR_W   = SLOT_W + 1;
    localparam int ADDR_W  = SLOT_W + 1;
    localparam int STORE_W = (TASK_BITS < TASK_W) ? TASK_BITS : TASK_W;
    localparam int CMP_W   = (PTR_W > BATCH_W) ? PTR_W : BATCH_W;

    // Sequencer and latched request.
    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic                 prio_reg;
    logic [STORE_W-1:0]   task_reg;
    logic [BATCH_W-1:0]   limit_reg;
    logic                 sel_reg, sel_next;
    logic [BATCH_W-1:0]   rem_reg, rem_next;

    // Deque pointers.
    logic [PTR_W-1:0]     hi_top_reg, hi_top_next;
    logic [PTR_W-1:0]     hi_bot_reg, hi_bot_next;
    logic [PTR_W-1:0]     nm_top_reg, nm_top_next;
    logic [PTR_W-1:0]     nm_bot_reg, nm_bot_next;

    // Task memory with a registered read.
    logic [STORE_W-1:0]   mem [2*DEPTH];
    logic [STORE_W-1:0]   rdata_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_addr;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [TASK_W-1:0]    out_task_reg, out_task_next;
    status_t              out_status_reg, out_status_next;
    logic                 out_last_reg, out_last_next;
    logic [LEVEL_W-1:0]   out_hl_reg, out_hl_next;
    logic [LEVEL_W-1:0]   out_nl_reg, out_nl_next;

    // Fill levels and the batch size for the current state of the deques.
    logic [PTR_W-1:0]     hi_fill;
    logic [PTR_W-1:0]     nm_fill;
    logic                 hi_any;
    logic                 nm_any;
    logic [PTR_W-1:0]     sel_fill;
    logic [PTR_W-1:0]     half_fill;
    logic [CMP_W-1:0]     half_x;
    logic [CMP_W-1:0]     limit_x;
    logic [BATCH_W-1:0]   batch_n;
    logic [BATCH_W-1:0]   limit_in;
    logic                 out_free;
    logic                 accept;

    // Shared pointer unit controls.
    logic                 upd_en;
    logic                 upd_hi;
    logic                 upd_bot;
    logic                 upd_down;
    logic [PTR_W-1:0]     ptr_cur;
    logic [PTR_W-1:0]     ptr_new;
    logic [PTR_W-1:0]     addr_ptr;

    // Emission controls.
    logic                 emit;
    status_t              emit_status;
    logic                 emit_last;
    logic                 emit_data;

    assign hi_fill   = hi_bot_reg - hi_top_reg;
    assign nm_fill   = nm_bot_reg - nm_top_reg;
    assign hi_any    = (hi_fill != '0);
    assign nm_any    = (nm_fill != '0);

    // A batch steal takes half of the chosen deque, rounded up, capped by the
    // saturated limit that was latched with the request.
    assign sel_fill  = hi_any ? hi_fill : nm_fill;
    assign half_fill = (sel_fill + PTR_W'(1)) >> 1;
    assign half_x    = CMP_W'(half_fill);
    assign limit_x   = CMP_W'(limit_reg);
    assign batch_n   = (half_x < limit_x) ? BATCH_W'(half_x) : limit_reg;

    assign limit_in  = (req.max_batch > BATCH_W'(MAX_BATCH)) ? BATCH_W'(MAX_BATCH)
                                                             : req.max_batch;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        rem_next        = rem_reg;
        upd_en          = 1'b0;
        upd_hi          = sel_reg;
        upd_bot         = 1'b0;
        upd_down        = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        emit            = 1'b0;
        emit_status     = ST_OK;
        emit_last       = 1'b1;
        emit_data       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                unique case (op_reg)
                    OP_PUSH:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if ((prio_reg ? hi_fill[PTR_W-1] : nm_fill[PTR_W-1]))
                            begin
                                emit_status = ST_FULL;
                            end
                            else
                            begin
                                // Write at the old bottom, then advance it.
                                upd_en  = 1'b1;
                                upd_hi  = prio_reg;
                                upd_bot = 1'b1;
                                mem_we  = 1'b1;
                            end
                        end
                    end

                    OP_POP, OP_STEAL:
                    begin
                        if (!hi_any && !nm_any)
                        begin
                            if (out_free)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_EMPTY;
                                state_next  = S_IDLE;
                            end
                        end
                        else
                        begin
                            sel_next   = hi_any;
                            rem_next   = BATCH_W'(1);
                            upd_en     = 1'b1;
                            upd_hi     = hi_any;
                            upd_bot    = (op_reg == OP_POP);
                            upd_down   = (op_reg == OP_POP);
                            mem_re     = 1'b1;
                            state_next = S_READ;
                        end
                    end

                    OP_BATCH:
                    begin
                        if (batch_n == '0)
                        begin
                            if (out_free)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_EMPTY;
                                state_next  = S_IDLE;
                            end
                        end
                        else
                        begin
                            sel_next   = hi_any;
                            rem_next   = batch_n;
                            upd_en     = 1'b1;
                            upd_hi     = hi_any;
                            mem_re     = 1'b1;
                            state_next = S_READ;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_READ:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_data = 1'b1;
                    emit_last = (rem_reg == BATCH_W'(1));
                    if (rem_reg == BATCH_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // Next task of the batch comes off the top.
                        rem_next = rem_reg - BATCH_W'(1);
                        upd_en   = 1'b1;
                        upd_hi   = sel_reg;
                        mem_re   = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Shared pointer unit: one pointer selected, stepped by one.
        unique case ({upd_hi, upd_bot})
            2'b11:   ptr_cur = hi_bot_reg;
            2'b10:   ptr_cur = hi_top_reg;
            2'b01:   ptr_cur = nm_bot_reg;
            default: ptr_cur = nm_top_reg;
        endcase
        ptr_new  = upd_down ? (ptr_cur - PTR_W'(1)) : (ptr_cur + PTR_W'(1));
        addr_ptr = upd_down ? ptr_new : ptr_cur;
        mem_addr = {upd_hi, addr_ptr[SLOT_W-1:0]};

        hi_top_next = hi_top_reg;
        hi_bot_next = hi_bot_reg;
        nm_top_next = nm_top_reg;
        nm_bot_next = nm_bot_reg;
        if (upd_en)
        begin
            unique case ({upd_hi, upd_bot})
                2'b11:   hi_bot_next = ptr_new;
                2'b10:   hi_top_next = ptr_new;
                2'b01:   nm_bot_next = ptr_new;
                default: nm_top_next = ptr_new;
            endcase
        end

        // Output register: a word leaves when taken; a new one loads when
        // the sequencer emits. Levels after a push come from the updated
        // pointers; during a batch they exclude the next read issued here.
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_task_next   = out_task_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_hl_next     = out_hl_reg;
        out_nl_next     = out_nl_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_task_next   = emit_data ? TASK_W'(rdata_reg) : '0;
            out_status_next = emit_status;
            out_last_next   = emit_last;
            if (state_reg == S_READ)
            begin
                out_hl_next = LEVEL_W'(hi_fill);
                out_nl_next = LEVEL_W'(nm_fill);
            end
            else
            begin
                out_hl_next = LEVEL_W'(hi_bot_next - hi_top_next);
                out_nl_next = LEVEL_W'(nm_bot_next - nm_top_next);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            rem_reg       <= '0;
            hi_top_reg    <= '0;
            hi_bot_reg    <= '0;
            nm_top_reg    <= '0;
            nm_bot_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            rem_reg       <= rem_next;
            hi_top_reg    <= hi_top_next;
            hi_bot_reg    <= hi_bot_next;
            nm_top_reg    <= nm_top_next;
            nm_bot_reg    <= nm_bot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(req.op);
            prio_reg  <= req.priority_req;
            task_reg  <= req.task_req[STORE_W-1:0];
            limit_reg <= limit_in;
        end
        out_task_reg   <= out_task_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_hl_reg     <= out_hl_next;
        out_nl_reg     <= out_nl_next;
    end

    // Task memory: one port, never written and read in the same cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= task_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.task_out     = out_task_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.last         = out_last_reg;
    assign rsp.high_level   = out_hl_reg;
    assign rsp.normal_level = out_nl_reg;

endmodule

### hdl/dpwsd_checker.sv
// Port-level assertions for the dual priority work-stealing deque.
// Depends on dpwsd_pkg; bound to the top level at the end of this file.
module dpwsd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [dpwsd_pkg::TASK_W-1:0]   rsp_task_out,
    input logic [dpwsd_pkg::STATUS_W-1:0] rsp_status,
    input logic                           rsp_last,
    input logic [dpwsd_pkg::LEVEL_W-1:0]  rsp_high_level,
    input logic [dpwsd_pkg::LEVEL_W-1:0]  rsp_normal_level
);
    import dpwsd_pkg::*;

    // A response word that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response valid dropped while stalled");

    // A stalled response word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_task_out) && $stable(rsp_status)
            && $stable(rsp_last) && $stable(rsp_high_level)
            && $stable(rsp_normal_level))
        else $error("response word changed while stalled");

    // The sequencer serves one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while the previous one is in progress");

    // An empty or full result carries no task and ends its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> (rsp_task_out == '0) && rsp_last)
        else $error("non-ok response with task or without last");

endmodule

bind dual_priority_work_steal_deque dpwsd_checker u_dpwsd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_task_out     (rsp.task_out),
    .rsp_status       (rsp.status),
    .rsp_last         (rsp.last),
    .rsp_high_level   (rsp.high_level),
    .rsp_normal_level (rsp.normal_level)
);
